// ===== design/triangle_plane_clip_project_assert.svh =====
// Assertion macros for the triangle clip and projection block.
`ifndef TRIANGLE_PLANE_CLIP_PROJECT_ASSERT_SVH
`define TRIANGLE_PLANE_CLIP_PROJECT_ASSERT_SVH

`ifndef SYNTHESIS
`define TPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/tpc_pkg.sv =====
package tpc_pkg;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;
  } tri_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] inv_depth;
    logic [1:0]         corner;
    logic               tri_number;
    logic               strip_end;
    logic               last;
  } result_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vtx_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_PASS,
    MODE_ONE,
    MODE_TWO
  } mode_e;

  typedef struct packed {
    mode_e mode;
    vtx_t  p0;
    vtx_t  p1;
    vtx_t  p2;
  } entry_t;

  typedef enum logic [2:0] {
    SRC_P0,
    SRC_P1,
    SRC_P2,
    SRC_C02,
    SRC_C01,
    SRC_C12
  } src_e;

  typedef enum logic [1:0] {
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z,
    REG_CLIP_ENABLE
  } reg_e;

  localparam logic [1:0]         CORNER_LAST = 2'd2;
  localparam logic signed [31:0] SAT_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN     = -32'sh8000_0000;
  localparam logic signed [40:0] SCALE       = 41'sd240;
  localparam logic signed [40:0] X_BIAS      = 41'sd20971520;
  localparam logic signed [40:0] Y_BIAS      = 41'sd15728640;
  localparam logic signed [32:0] Q_ONE       = 33'sd65536;
  localparam logic [63:0]        INV_NUM     = 64'h0000_0001_0000_0000;

  function automatic logic signed [31:0] sat41(input logic signed [40:0] v);
    if (v > 41'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (v < 41'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [2:0] vert_count(input mode_e m);
    unique case (m)
      MODE_NONE: return 3'd0;
      MODE_TWO:  return 3'd6;
      default:   return 3'd3;
    endcase
  endfunction

  function automatic src_e vertex_src(input mode_e m, input logic [2:0] k);
    src_e s;
    s = SRC_P0;
    unique case (m)
      MODE_ONE: begin
        if (k == 3'd1) s = SRC_C02;
        else if (k == 3'd2) s = SRC_C01;
      end
      MODE_TWO: begin
        unique case (k)
          3'd1, 3'd3: s = SRC_P1;
          3'd2, 3'd5: s = SRC_C02;
          3'd4:       s = SRC_C12;
          default:    s = SRC_P0;
        endcase
      end
      default: begin
        if (k == 3'd1) s = SRC_P1;
        else if (k == 3'd2) s = SRC_P2;
      end
    endcase
    return s;
  endfunction

endpackage

// ===== design/tpc_queue.sv =====
module tpc_queue #(
  parameter type T = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T mem_q [DEPTH];
  logic [IDX_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == IDX_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/tpc_front.sv =====
module tpc_front (
  input  logic                 clip_en_i,
  input  logic signed [31:0]   off_x_i,
  input  logic signed [31:0]   off_y_i,
  input  logic signed [31:0]   off_z_i,
  input  tpc_pkg::tri_t        tri_i,
  output tpc_pkg::entry_t      entry_o
);

  tpc_pkg::vtx_t v [3];
  tpc_pkg::vtx_t p [3];
  logic signed [31:0] mx [3];
  logic signed [31:0] my [3];
  logic signed [31:0] mz [3];
  logic [1:0] ins, outs;

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? tpc_pkg::SAT_MIN : tpc_pkg::SAT_MAX;
    end
    return s[31:0];
  endfunction

  assign mx[0] = tri_i.first_x;
  assign my[0] = tri_i.first_y;
  assign mz[0] = tri_i.first_z;
  assign mx[1] = tri_i.second_x;
  assign my[1] = tri_i.second_y;
  assign mz[1] = tri_i.second_z;
  assign mx[2] = tri_i.third_x;
  assign my[2] = tri_i.third_y;
  assign mz[2] = tri_i.third_z;

  // halve, swap y and z, add the object offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i].x = add_sat(mx[i] >>> 1, off_x_i);
      v[i].y = add_sat(mz[i] >>> 1, off_y_i);
      v[i].z = add_sat(my[i] >>> 1, off_z_i);
    end
  end

  // inside vertices in order, outside ones from the back
  always_comb begin
    ins  = 2'd0;
    outs = 2'd0;
    for (int i = 0; i < 3; i++) begin
      p[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      if (!clip_en_i || v[i].x[31]) begin
        p[ins] = v[i];
        ins    = ins + 2'd1;
      end else begin
        p[2'd2 - outs] = v[i];
        outs           = outs + 2'd1;
      end
    end
  end

  always_comb begin
    entry_o.p0 = p[0];
    entry_o.p1 = p[1];
    entry_o.p2 = p[2];
    if (!clip_en_i || ins == 2'd3) begin
      entry_o.mode = tpc_pkg::MODE_PASS;
    end else if (ins == 2'd0) begin
      entry_o.mode = tpc_pkg::MODE_NONE;
    end else if (ins == 2'd1) begin
      entry_o.mode = tpc_pkg::MODE_ONE;
    end else begin
      entry_o.mode = tpc_pkg::MODE_TWO;
    end
  end

endmodule

// ===== design/tpc_div.sv =====
module tpc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [63:0] num_q, quo_q, num_d, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q;

  // two restoring steps per cycle
  always_comb begin
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < 2; i++) begin
      rem_d = {rem_d[32:0], num_d[63]};
      num_d = {num_d[62:0], 1'b0};
      if (rem_d >= {1'b0, den_q}) begin
        rem_d = rem_d - {1'b0, den_q};
        quo_d = {quo_d[62:0], 1'b1};
      end else begin
        quo_d = {quo_d[62:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        num_q <= num_d;
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/tpc_back.sv =====
module tpc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpc_pkg::entry_t     entry_i,
  input  logic                entry_empty_i,
  output logic                entry_pop_o,
  output logic                res_push_o,
  output tpc_pkg::result_t    res_o,
  input  logic                res_full_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEL, ST_DY_GO, ST_DY_WAIT, ST_DZ_GO, ST_DZ_WAIT,
    ST_PROJ, ST_INV_GO, ST_INV_WAIT, ST_OUT
  } state_e;

  state_e state_q;
  tpc_pkg::entry_t ent_q;
  logic [2:0] k_q, nv;
  tpc_pkg::src_e src;
  tpc_pkg::vtx_t a, b, pv;
  logic signed [31:0] vx_q, vy_q, vz_q, sx_q, sy_q, inv_q;
  logic [63:0] num_q;
  logic [32:0] den_q;
  logic        neg_q;
  logic        div_start, div_done;
  logic [63:0] quo;
  logic signed [31:0] qs;
  logic signed [32:0] dx, dy, dz, zp;
  logic signed [64:0] py, pz;
  logic signed [40:0] tx, ty;

  assign src = tpc_pkg::vertex_src(ent_q.mode, k_q);
  assign nv  = tpc_pkg::vert_count(ent_q.mode);
  assign a   = (src == tpc_pkg::SRC_C12) ? ent_q.p1 : ent_q.p0;
  assign b   = (src == tpc_pkg::SRC_C01) ? ent_q.p1 : ent_q.p2;

  always_comb begin
    unique case (src)
      tpc_pkg::SRC_P1: pv = ent_q.p1;
      tpc_pkg::SRC_P2: pv = ent_q.p2;
      default:         pv = ent_q.p0;
    endcase
  end

  // cut at x=0: a.c + (b.c - a.c) * a.x / (a.x - b.x), divisor always negative
  assign dx = {a.x[31], a.x} - {b.x[31], b.x};
  assign dy = {b.y[31], b.y} - {a.y[31], a.y};
  assign dz = {b.z[31], b.z} - {a.z[31], a.z};
  assign py = dy * a.x;
  assign pz = dz * a.x;
  assign qs = neg_q ? -quo[31:0] : quo[31:0];

  assign tx = {{9{vx_q[31]}}, vx_q} * tpc_pkg::SCALE + tpc_pkg::X_BIAS;
  assign ty = {{9{vy_q[31]}}, vy_q} * tpc_pkg::SCALE + tpc_pkg::Y_BIAS;
  assign zp = {vz_q[31], vz_q} + tpc_pkg::Q_ONE;

  assign div_start   = (state_q == ST_DY_GO) || (state_q == ST_DZ_GO)
                    || (state_q == ST_INV_GO);
  assign entry_pop_o = (state_q == ST_IDLE) && !entry_empty_i;
  assign res_push_o  = (state_q == ST_OUT) && !res_full_i;

  always_comb begin
    res_o.screen_x   = sx_q;
    res_o.screen_y   = sy_q;
    res_o.inv_depth  = inv_q;
    res_o.tri_number = (k_q >= 3'd3);
    res_o.corner     = (k_q >= 3'd3) ? 2'(k_q - 3'd3) : k_q[1:0];
    res_o.strip_end  = (res_o.corner == tpc_pkg::CORNER_LAST);
    res_o.last       = (k_q == nv - 3'd1);
  end

  tpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (!entry_empty_i) begin
            ent_q <= entry_i;
            k_q   <= '0;
            // drop triangles that lie wholly outside
            state_q <= (entry_i.mode == tpc_pkg::MODE_NONE) ? ST_IDLE : ST_SEL;
          end
        end
        ST_SEL: begin
          if (src == tpc_pkg::SRC_P0 || src == tpc_pkg::SRC_P1
              || src == tpc_pkg::SRC_P2) begin
            vx_q    <= pv.x;
            vy_q    <= pv.y;
            vz_q    <= pv.z;
            state_q <= ST_PROJ;
          end else begin
            num_q   <= py[63] ? -py[63:0] : py[63:0];
            neg_q   <= !py[63];
            den_q   <= -dx;
            state_q <= ST_DY_GO;
          end
        end
        ST_DY_GO: state_q <= ST_DY_WAIT;
        ST_DY_WAIT: begin
          if (div_done) begin
            vy_q    <= a.y + qs;
            num_q   <= pz[63] ? -pz[63:0] : pz[63:0];
            neg_q   <= !pz[63];
            state_q <= ST_DZ_GO;
          end
        end
        ST_DZ_GO: state_q <= ST_DZ_WAIT;
        ST_DZ_WAIT: begin
          if (div_done) begin
            vz_q    <= a.z + qs;
            vx_q    <= '0;
            state_q <= ST_PROJ;
          end
        end
        ST_PROJ: begin
          sx_q <= tpc_pkg::sat41(tx);
          sy_q <= tpc_pkg::sat41(ty);
          if (zp == '0) begin
            inv_q   <= tpc_pkg::SAT_MAX;
            state_q <= ST_OUT;
          end else begin
            num_q   <= tpc_pkg::INV_NUM;
            den_q   <= zp[32] ? -zp : zp;
            neg_q   <= zp[32];
            state_q <= ST_INV_GO;
          end
        end
        ST_INV_GO: state_q <= ST_INV_WAIT;
        ST_INV_WAIT: begin
          if (div_done) begin
            if (!neg_q) begin
              inv_q <= (quo > 64'h7FFF_FFFF) ? tpc_pkg::SAT_MAX : quo[31:0];
            end else begin
              inv_q <= (quo > 64'h8000_0000) ? tpc_pkg::SAT_MIN : -quo[31:0];
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res_full_i) begin
            if (k_q == nv - 3'd1) begin
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= ST_SEL;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/triangle_plane_clip_project.sv =====
// Triangle transform, clip against x=0 and screen projection.
// Input channel: a whole triangle (three Q16.16 vertices) is written as one
// item with push while full is low. Output channel: projected vertices are
// read as a queue; the head is valid while empty is low and leaves on pop.
// Each triangle gives 0, 3 or 6 vertices, tagged with corner, triangle
// number, strip end and last.
// The front transforms and classifies a triangle in the cycle it is pushed
// and hands it to a short queue; the back walks its output vertices.
// The back runs every division on one shared divider (two quotient bits per
// cycle while busy): two for a cut vertex, one for 1/(z+1). The back finishes
// one output vertex before it starts on the next one.
// Configuration is written through cfg_valid_i/cfg_ready_o (always ready).
// Reset clears the queues and the sequencer; offsets reset to zero and
// clipping to on. A receiver that stops popping fills the output queue,
// which halts the back and then the input queue; nothing is lost.
`include "triangle_plane_clip_project_assert.svh"

module triangle_plane_clip_project #(
  parameter int unsigned ENTRY_DEPTH  = 2,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  tpc_pkg::tri_t     tri_i,
  output logic              empty,
  input  logic              pop,
  output tpc_pkg::result_t  res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  logic signed [31:0] off_x_q, off_y_q, off_z_q;
  logic clip_en_q;
  tpc_pkg::entry_t ent_in, ent_head;
  logic ent_empty, ent_pop;
  logic res_push, res_full;
  tpc_pkg::result_t res_in;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q   <= '0;
      off_y_q   <= '0;
      off_z_q   <= '0;
      clip_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (tpc_pkg::reg_e'(cfg_index_i))
        tpc_pkg::REG_OFFSET_X:    off_x_q   <= cfg_data_i;
        tpc_pkg::REG_OFFSET_Y:    off_y_q   <= cfg_data_i;
        tpc_pkg::REG_OFFSET_Z:    off_z_q   <= cfg_data_i;
        tpc_pkg::REG_CLIP_ENABLE: clip_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tpc_front u_front (
    .clip_en_i (clip_en_q),
    .off_x_i   (off_x_q),
    .off_y_i   (off_y_q),
    .off_z_i   (off_z_q),
    .tri_i     (tri_i),
    .entry_o   (ent_in)
  );

  tpc_queue #(.T(tpc_pkg::entry_t), .DEPTH(ENTRY_DEPTH)) u_entry_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ent_in),
    .full_o  (full),
    .pop_i   (ent_pop),
    .data_o  (ent_head),
    .empty_o (ent_empty)
  );

  tpc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (ent_head),
    .entry_empty_i (ent_empty),
    .entry_pop_o   (ent_pop),
    .res_push_o    (res_push),
    .res_o         (res_in),
    .res_full_i    (res_full)
  );

  tpc_queue #(.T(tpc_pkg::result_t), .DEPTH(RESULT_DEPTH)) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty)
  );

  `TPC_ASSERT(a_strip_end_corner, clk_i, rst_ni, !empty && res_o.strip_end |-> res_o.corner == tpc_pkg::CORNER_LAST, "strip end off the last corner")
  `TPC_ASSERT(a_last_ends_strip, clk_i, rst_ni, !empty && res_o.last |-> res_o.strip_end, "last vertex not closing a triangle")
  `TPC_ASSERT(a_push_lands, clk_i, rst_ni, res_push && !res_full |=> !empty, "pushed vertex not visible")

endmodule
